// File: sv/bounded_deque_with_search_unit_assert.svh
// assertion macros for the bounded deque with search unit
// expects clk_i and rst_ni in the scope of the including module
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define BDQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define BDQS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/bdqs_pkg.sv
// package for the bounded deque with search unit
// command and status codes, cell control types; no dependencies
`timescale 1ns / 1ps

package bdqs_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 48;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage

// File: sv/bdqs_cell.sv
// one storage cell of the deque chain: holds an entry and a match flag
// depends on bdqs_pkg
`timescale 1ns / 1ps

module bdqs_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdqs_pkg::cell_ctrl_t      ctrl_i,
  input  logic [bdqs_pkg::DATA_W-1:0] key_i,
  input  logic [bdqs_pkg::DATA_W-1:0] load_i,
  input  logic [bdqs_pkg::DATA_W-1:0] left_i,
  input  logic [bdqs_pkg::DATA_W-1:0] right_i,
  output logic [bdqs_pkg::DATA_W-1:0] value_o,
  output logic                      match_o
);
  import bdqs_pkg::*;

  logic [DATA_W-1:0] value_q, value_d;
  logic              match_q, match_d;

  always_comb begin
    case (ctrl_i.op)
      CELL_LOAD:       value_d = load_i;
      CELL_FROM_LEFT:  value_d = left_i;
      CELL_FROM_RIGHT: value_d = right_i;
      default:         value_d = value_q;
    endcase
    match_d = ctrl_i.cmp_en ? (value_q == key_i) : match_q;
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// File: sv/bounded_deque_with_search_unit.sv
// top level of the bounded deque with search: control, result register, cell chain
// depends on bdqs_pkg, bdqs_cell and bounded_deque_with_search_unit_assert.svh
// channel  | dir | tdata fields (lsb first)
// s_axis   | in  | cmd[2:0], value[34:3], zero pad to 40 bits
// m_axis   | out | status[1:0], position[8:2], data[40:9], count[47:41]
// each command has an accept step and an execute step: on accept every cell compares the key,
// the execute step picks the first match and shifts the chain in one step
// a result that is not taken holds the execute cycle; a new command is
// accepted while the previous result still waits
// rst_ni clears the count, match flags and handshake state; entries are not cleared
`timescale 1ns / 1ps

module bounded_deque_with_search_unit #(
  parameter int unsigned CAPACITY = bdqs_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bdqs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // cmd, value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bdqs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // status, position, data, count
);
  import bdqs_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e            state_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q;
  logic [STATUS_W-1:0] out_status_q, status_d;
  logic [CntW-1:0]   out_pos_q, pos_d;
  logic [DATA_W-1:0] out_data_q, data_d;
  logic [CntW-1:0]   out_count_q;

  logic              in_fire, exec_fire, full, empty, found;
  logic [IdxW-1:0]   match_idx;
  logic [CntW-1:0]   last_cnt;
  logic [IdxW-1:0]   last_idx;
  logic [CAPACITY-1:0] match_raw, match_vec;
  logic [DATA_W-1:0] cell_val [CAPACITY];
  cell_ctrl_t        cell_ctrl [CAPACITY];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign full          = (count_q == CntW'(CAPACITY));
  assign empty         = (count_q == '0);
  assign last_cnt      = count_q - CntW'(1);
  assign last_idx      = last_cnt[IdxW-1:0];

  always_comb begin
    match_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = match_raw[i] && (CntW'(i) < count_q);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_idx = IdxW'(i);
      end
    end
    found = |match_vec;
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].cmp_en = in_fire;
      cell_ctrl[i].op     = CELL_HOLD;
      if (exec_fire) begin
        unique case (cmd_q)
          CMD_PUSH_FRONT: begin
            if (!full) cell_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
          end
          CMD_PUSH_BACK: begin
            if (!full && count_q == CntW'(i)) cell_ctrl[i].op = CELL_LOAD;
          end
          CMD_REMOVE: begin
            if (found && IdxW'(i) >= match_idx) cell_ctrl[i].op = CELL_FROM_RIGHT;
          end
          CMD_POP_FRONT: begin
            if (!empty) cell_ctrl[i].op = CELL_FROM_RIGHT;
          end
          default: cell_ctrl[i].op = CELL_HOLD;
        endcase
      end
    end
  end

  always_comb begin
    status_d = STAT_OK;
    pos_d    = '0;
    data_d   = '0;
    count_d  = count_q;
    unique case (cmd_q)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          data_d  = val_q;
          count_d = count_q + CntW'(1);
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else if (!found) begin
          status_d = STAT_NOT_FOUND;
        end else begin
          pos_d  = CntW'(match_idx) + CntW'(1);
          data_d = val_q;
          if (cmd_q == CMD_REMOVE) count_d = last_cnt;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          data_d  = cell_val[last_idx];
          count_d = last_cnt;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          data_d  = cell_val[0];
          count_d = last_cnt;
        end
      end
      default: status_d = STAT_OK;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = val_q;
    end else begin : g_mid
      assign left_val = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_inner
      assign right_val = cell_val[g+1];
    end
    bdqs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[g]),
      .key_i   (s_axis_tdata[CMD_W +: DATA_W]),
      .load_i  (val_q),
      .left_i  (left_val),
      .right_i (right_val),
      .value_o (cell_val[g]),
      .match_o (match_raw[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= exec_fire || (out_valid_q && !m_axis_tready);
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state_q <= ST_IDLE;
            count_q <= count_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= s_axis_tdata[CMD_W-1:0];
      val_q <= s_axis_tdata[CMD_W +: DATA_W];
    end
    if (exec_fire) begin
      out_status_q <= status_d;
      out_pos_q    <= pos_d;
      out_data_q   <= data_d;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {COUNT_W'(out_count_q), out_data_q, POS_W'(out_pos_q), out_status_q};

  `include "bounded_deque_with_search_unit_assert.svh"

  `BDQS_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY), "count above capacity")
  `BDQS_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "accept not followed by exec")
  `BDQS_ASSERT_NEXT(a_count_stable, !exec_fire, $stable(count_q), "count moved without exec")
  `BDQS_ASSERT(a_full_status, !out_valid_q || out_status_q != STAT_FULL || out_count_q == CntW'(CAPACITY), "full reported below capacity")
  `BDQS_ASSERT(a_empty_status, !out_valid_q || out_status_q != STAT_EMPTY || out_count_q == '0, "empty reported with entries")

endmodule

// File: tb/testbench.sv
// self-checking testbench for bounded_deque_with_search_unit: directed and random commands
// checks every result against a deque model kept inside the bench; depends on bdqs_pkg
`timescale 1ns / 1ps

module testbench;
  import bdqs_pkg::*;

  localparam int          DEPTH          = CAPACITY_DEF;
  localparam int          CLK_PERIOD     = 8;
  localparam int          RESET_CYCLES   = 5;
  localparam int          HOLD_CYCLES    = 200;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          RANDOM_ITEMS   = 1250;
  localparam logic [2:0]  CMD_UNUSED_6   = 3'd6;
  localparam logic [2:0]  CMD_UNUSED_7   = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [CMD_W-1:0]         cmd;
  } deque_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [STATUS_W-1:0]      status;
  } deque_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  deque_cmd_t      cmd_backlog[$];
  deque_result_t   expected_results[$];
  logic [31:0]     model_entries[$];
  int              n_errors = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_requests = 0;
  int              hold_served = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  logic [31:0]     key_pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'h0000_0001, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0001_0000};

  bounded_deque_with_search_unit #(.CAPACITY(DEPTH)) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,   // cmd, value
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata    // status, position, data, count
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic deque_result_t apply_command(deque_cmd_t c);
    deque_result_t r;
    int            hit;
    r = '0;
    r.status = STAT_OK;
    hit = -1;
    case (c.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (model_entries.size() >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (c.cmd == CMD_PUSH_FRONT) model_entries.push_front(c.value);
          else model_entries.push_back(c.value);
          r.data = c.value;
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        if (model_entries.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = model_entries.size() - 1; i >= 0; i--)
            if (model_entries[i] == c.value) hit = i;
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.position = POS_W'(hit + 1);
            r.data = model_entries[hit];
            if (c.cmd == CMD_REMOVE) model_entries.delete(hit);
          end
        end
      end
      CMD_POP_BACK: begin
        if (model_entries.size() == 0) r.status = STAT_EMPTY;
        else r.data = model_entries.pop_back();
      end
      CMD_POP_FRONT: begin
        if (model_entries.size() == 0) r.status = STAT_EMPTY;
        else r.data = model_entries.pop_front();
      end
      default: ;
    endcase
    r.count = COUNT_W'(model_entries.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  // sender side
  always @(posedge clk_i) begin
    logic fire;
    logic go;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        expected_results.push_back(apply_command(cmd_backlog[0]));
        void'(cmd_backlog.pop_front());
      end
      if (!s_axis_tvalid || fire) begin
        go = cmd_backlog.size() != 0 &&
             !(send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct);
        s_axis_tvalid <= go;
        if (go) s_axis_tdata <= IN_TDATA_W'(cmd_backlog[0]);
      end
    end
  end

  // receiver side
  always @(posedge clk_i) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = deque_result_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending", m_axis_tdata[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.position !== want.position)
            report_mismatch("position", got.position, want.position);
          if (got.data !== want.data) report_mismatch("data", got.data, want.data);
          if (got.count !== want.count) report_mismatch("count", got.count, want.count);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        stall_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cmd_backlog.size() == 0 && expected_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [31:0] value);
    deque_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    cmd_backlog.push_back(c);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // push-heavy bursts drive the list toward full, pop-heavy bursts drain it past empty; others are mixed
  task automatic queue_random(input int n_items);
    int               left;
    int               burst;
    int               push_pct;
    int               r;
    logic [CMD_W-1:0] cmd;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(20, 60);
      if (burst > left) burst = left;
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < burst; i++) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
          case ($urandom_range(0, 32))
            0:              cmd = CMD_UNUSED_6;
            1:              cmd = CMD_UNUSED_7;
            2, 3, 4, 5, 6, 7, 8, 9:
                            cmd = CMD_REMOVE;
            10, 11, 12, 13, 14, 15, 16:
                            cmd = CMD_POP_BACK;
            17, 18, 19, 20, 21, 22, 23:
                            cmd = CMD_POP_FRONT;
            default:        cmd = CMD_FIND;
          endcase
        end
        queue_cmd(cmd, pick_value());
      end
      left -= burst;
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_cmd(CMD_POP_FRONT, 32'h0);
    queue_cmd(CMD_POP_BACK, 32'h0);
    queue_cmd(CMD_FIND, 32'h0);
    queue_cmd(CMD_REMOVE, 32'h0);
    queue_cmd(CMD_UNUSED_6, 32'hFFFF_FFFF);
    queue_cmd(CMD_UNUSED_7, 32'h1234_5678);
    queue_cmd(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    queue_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    queue_cmd(CMD_PUSH_BACK, 32'h0000_0000);
    queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    queue_cmd(CMD_PUSH_BACK, 32'h0000_0005);
    queue_cmd(CMD_PUSH_BACK, 32'h0000_0005);
    queue_cmd(CMD_FIND, 32'h0000_0005);
    queue_cmd(CMD_FIND, 32'hFFFF_FFFE);
    queue_cmd(CMD_REMOVE, 32'h0000_0005);
    queue_cmd(CMD_FIND, 32'h0000_0005);
    queue_cmd(CMD_REMOVE, 32'h1234_5678);
    queue_cmd(CMD_POP_FRONT, 32'h0);
    queue_cmd(CMD_POP_BACK, 32'h0);
    queue_cmd(CMD_UNUSED_6, 32'h0);
    queue_cmd(CMD_REMOVE, 32'h8000_0000);
    queue_cmd(CMD_FIND, 32'h0000_0000);
    queue_cmd(CMD_POP_BACK, 32'h0);
    queue_cmd(CMD_POP_FRONT, 32'h0);
    queue_cmd(CMD_POP_BACK, 32'h0);
    wait_drained();

    // no idling, with one long receiver hold while the sender keeps offering
    hold_requests++;
    queue_random(RANDOM_ITEMS / 4);
    wait_drained();

    send_idle_pct = 58;
    recv_stall_pct = 0;
    queue_random(RANDOM_ITEMS / 4);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 58;
    queue_random(RANDOM_ITEMS / 4);
    wait_drained();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    queue_random(RANDOM_ITEMS / 4);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/bdqs_pkg.sv
sv/bdqs_cell.sv
sv/bounded_deque_with_search_unit.sv
tb/testbench.sv
